// ===== rtl/vpc_pkg.sv =====
// ----------------------------------------------------------------------------
// vpc_pkg: shared definitions for the packet classifier
// Types, codes and fixed sizes used by the classifier modules and checker.
// ----------------------------------------------------------------------------
package vpc_pkg;

   // Default sizes for the top-level parameters
   localparam int DEF_NUM_SLOTS     = 4;
   localparam int DEF_TRACK_ENTRIES = 16;
   localparam int MAX_SLOTS         = 4;

   // Fixed packet geometry
   localparam int HEADER_BYTES  = 28;
   localparam int TRAILER_BYTES = 4;
   localparam int TRAILER_BIT   = 26;
   localparam int SEQ_LSB       = 16;
   localparam int SEQ_W         = 4;
   localparam int WCOUNT_W      = 3;

   // Word positions captured from the header
   localparam logic [WCOUNT_W-1:0] POS_WORD0  = 3'd0;
   localparam logic [WCOUNT_W-1:0] POS_STREAM = 3'd1;
   localparam logic [WCOUNT_W-1:0] POS_CLASS  = 3'd3;
   localparam logic [WCOUNT_W-1:0] POS_SAT    = 3'd7;

   // Packet class codes
   localparam logic [15:0] CC_NARROW    = 16'h03E3;
   localparam logic [15:0] CC_REDUCED   = 16'h0123;
   localparam logic [15:0] CC_OPUS      = 16'h8005;
   localparam logic [15:0] CC_FFT       = 16'h8003;
   localparam logic [15:0] CC_WATERFALL = 16'h8004;
   localparam logic [15:0] CC_METER     = 16'h8002;
   localparam logic [15:0] CC_IQ24      = 16'h02E3;
   localparam logic [15:0] CC_IQ48      = 16'h02E4;
   localparam logic [15:0] CC_IQ96      = 16'h02E5;
   localparam logic [15:0] CC_IQ192     = 16'h02E6;

   // Slot kinds, 3 bits per slot
   localparam int          KIND_W   = 3;
   localparam logic [2:0]  KIND_AUX = 3'd1;
   localparam logic [2:0]  KIND_IQ  = 3'd2;
   localparam logic [2:0]  KIND_PAN = 3'd3;
   localparam logic [2:0]  KIND_WF  = 3'd4;
   localparam int          CHAN_W   = 8;

   // Register indexes on the CSR port
   localparam int          CSR_IDX_W         = 3;
   localparam logic [2:0]  CSR_SLOT_KINDS    = 3'd4;
   localparam logic [2:0]  CSR_SLOT_CHANNELS = 3'd5;

   // IQ rate codes
   localparam logic [1:0]  RATE_24K  = 2'd0;
   localparam logic [1:0]  RATE_48K  = 2'd1;
   localparam logic [1:0]  RATE_96K  = 2'd2;
   localparam logic [1:0]  RATE_192K = 2'd3;

   localparam int NUM_CATS = 5;

   typedef enum logic [3:0] {
      ACT_DROP,
      ACT_AUX_NARROW,
      ACT_AUX_REDUCED,
      ACT_IQ,
      ACT_NARROW,
      ACT_REDUCED,
      ACT_OPUS,
      ACT_FFT,
      ACT_WATERFALL,
      ACT_METER
   } action_type;

   typedef enum logic [2:0] {
      CAT_NONE,
      CAT_AUX,
      CAT_AUDIO,
      CAT_FFT,
      CAT_WATERFALL,
      CAT_METER
   } category_type;

   // Header fields of one complete packet
   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] stream_id;
      logic [15:0] class_code;
      logic [15:0] bytes;
   } pkt_type;

   // One classification result
   typedef struct packed {
      action_type   action;
      category_type category;
      logic [31:0]  stream_id;
      logic [7:0]   channel;
      logic [1:0]   iq_rate_code;
      logic         seq_error;
      logic [15:0]  packet_bytes;
      logic [15:0]  payload_bytes;
      logic         has_trailer;
      logic [15:0]  class_code;
      logic         stats_full;
      logic [31:0]  category_errors;
   } rsp_type;

endpackage

// ===== rtl/vita49_packet_classifier.sv =====
// ----------------------------------------------------------------------------
// vita49_packet_classifier: datagram classifier for extension-data packets
// Assembles header fields from a word stream and emits one classification
// result per datagram, with per-stream sequence checking.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   -------  ---------  ---------------------  ------------------------------
//   req      in         req_valid / req_ready  word, last, bytes_in_word
//   rsp      out        rsp_valid / rsp_ready  classification of one datagram
//   csr      in         csr_valid / csr_ready  csr_index, csr_data (slots)
//
// Cycles: one word is taken per cycle unless the packet register is full and
//   its result is held. The edge that takes a datagram's last word loads its
//   header into the packet register, where the classify logic resolves it;
//   the result register loads when the pipe advances.
// The classify stage resolves the stream table and commits its update in
//   the same cycle, so back-to-back datagrams see each other's updates.
// Reset clears the header accumulators, the stream table fill count and
//   the error counters; no sweep is needed.
// Stalls: a held result blocks the packet register only when it is full;
//   the csr port is always ready.
//
module vita49_packet_classifier #(
   parameter int NUM_SLOTS     = vpc_pkg::DEF_NUM_SLOTS,
   parameter int TRACK_ENTRIES = vpc_pkg::DEF_TRACK_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   // input words
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [31:0]                   req_word,
   input  logic                          req_last,
   input  logic [2:0]                    req_bytes_in_word,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_action,
   output logic [2:0]                    rsp_category,
   output logic [31:0]                   rsp_stream_id,
   output logic [7:0]                    rsp_channel,
   output logic [1:0]                    rsp_iq_rate_code,
   output logic                          rsp_seq_error,
   output logic [15:0]                   rsp_packet_bytes,
   output logic [15:0]                   rsp_payload_bytes,
   output logic                          rsp_has_trailer,
   output logic [15:0]                   rsp_class_code,
   output logic                          rsp_stats_full,
   output logic [31:0]                   rsp_category_errors,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import vpc_pkg::*;

   // Configuration registers
   logic [NUM_SLOTS-1:0][31:0] slot_id_ff;
   logic [11:0]                slot_kinds_ff;
   logic [31:0]                slot_channels_ff;

   // Per-packet accumulators
   logic [31:0]          word0_ff,  word0_in;
   logic [31:0]          stream_ff, stream_in;
   logic [15:0]          class_ff,  class_in;
   logic [15:0]          bytes_ff,  bytes_in;
   logic [WCOUNT_W-1:0]  wcount_ff, wcount_in;
   logic [2:0]           nb;
   logic [16:0]          bytes_sum;

   // Packet register and result register
   pkt_type  pkt_ff, pkt_in;
   logic     pkt_valid_ff;
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff;

   logic     req_fire;
   logic     advance;
   logic     commit;

   // Advance the pipe whenever the result slot is empty or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pkt_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign commit    = pkt_valid_ff && advance;
   assign csr_ready = 1'b1;

   // Configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_id_ff       <= '0;
         slot_kinds_ff    <= '0;
         slot_channels_ff <= '0;
      end else if (csr_valid) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (csr_index == CSR_IDX_W'(s)) begin
               slot_id_ff[s] <= csr_data;
            end
         end
         if (csr_index == CSR_SLOT_KINDS) begin
            slot_kinds_ff <= csr_data[11:0];
         end
         if (csr_index == CSR_SLOT_CHANNELS) begin
            slot_channels_ff <= csr_data;
         end
      end
   end

   // Header capture by word position, byte count saturating at 16 bits
   always_comb begin
      nb        = (req_bytes_in_word > 3'd4) ? 3'd4 : req_bytes_in_word;
      bytes_sum = {1'b0, bytes_ff} + 17'(nb);
      bytes_in  = bytes_sum[16] ? 16'hFFFF : bytes_sum[15:0];
      word0_in  = (wcount_ff == POS_WORD0)  ? req_word : word0_ff;
      stream_in = (wcount_ff == POS_STREAM) ? req_word : stream_ff;
      class_in  = (wcount_ff == POS_CLASS)  ? req_word[15:0] : class_ff;
      wcount_in = (wcount_ff == POS_SAT) ? wcount_ff : wcount_ff + WCOUNT_W'(1);

      pkt_in.word0      = word0_in;
      pkt_in.stream_id  = stream_in;
      pkt_in.class_code = class_in;
      pkt_in.bytes      = bytes_in;
   end

   // Accumulate on each word, drop back to zero after the last one
   always_ff @(posedge clock) begin
      if (reset) begin
         word0_ff  <= '0;
         stream_ff <= '0;
         class_ff  <= '0;
         bytes_ff  <= '0;
         wcount_ff <= '0;
      end else if (req_fire) begin
         if (req_last) begin
            word0_ff  <= '0;
            stream_ff <= '0;
            class_ff  <= '0;
            bytes_ff  <= '0;
            wcount_ff <= '0;
         end else begin
            word0_ff  <= word0_in;
            stream_ff <= stream_in;
            class_ff  <= class_in;
            bytes_ff  <= bytes_in;
            wcount_ff <= wcount_in;
         end
      end
   end

   // Packet register: holds a finished datagram's header until classified
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_valid_ff <= 1'b0;
      end else if (req_fire && req_last) begin
         pkt_valid_ff <= 1'b1;
      end else if (advance) begin
         pkt_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_last) begin
         pkt_ff <= pkt_in;
      end
   end

   vpc_classify #(
      .NUM_SLOTS     (NUM_SLOTS),
      .TRACK_ENTRIES (TRACK_ENTRIES)
   ) u_classify (
      .clock         (clock),
      .reset         (reset),
      .pkt_in        (pkt_ff),
      .commit        (commit),
      .slot_id       (slot_id_ff),
      .slot_kinds    (slot_kinds_ff),
      .slot_channels (slot_channels_ff),
      .rsp_out       (rsp_in)
   );

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = rsp_ff.action;
   assign rsp_category        = rsp_ff.category;
   assign rsp_stream_id       = rsp_ff.stream_id;
   assign rsp_channel         = rsp_ff.channel;
   assign rsp_iq_rate_code    = rsp_ff.iq_rate_code;
   assign rsp_seq_error       = rsp_ff.seq_error;
   assign rsp_packet_bytes    = rsp_ff.packet_bytes;
   assign rsp_payload_bytes   = rsp_ff.payload_bytes;
   assign rsp_has_trailer     = rsp_ff.has_trailer;
   assign rsp_class_code      = rsp_ff.class_code;
   assign rsp_stats_full      = rsp_ff.stats_full;
   assign rsp_category_errors = rsp_ff.category_errors;

endmodule

// ===== rtl/vpc_classify.sv =====
// ----------------------------------------------------------------------------
// vpc_classify: packet classification and stream tracking
// Decodes one finished packet, owns the per-stream sequence table and the
// per-category error counters, which advance when the result is committed.
// ----------------------------------------------------------------------------
module vpc_classify #(
   parameter int NUM_SLOTS     = vpc_pkg::DEF_NUM_SLOTS,
   parameter int TRACK_ENTRIES = vpc_pkg::DEF_TRACK_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vpc_pkg::pkt_type              pkt_in,
   input  logic                          commit,
   input  logic [NUM_SLOTS-1:0][31:0]    slot_id,
   input  logic [11:0]                   slot_kinds,
   input  logic [31:0]                   slot_channels,
   output vpc_pkg::rsp_type              rsp_out
);
   import vpc_pkg::*;

   localparam int TRACK_W = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
   localparam int FILL_W  = $clog2(TRACK_ENTRIES + 1);

   // Entries are only ever appended, so the valid ones form a prefix
   logic [31:0]        track_stream_ff [TRACK_ENTRIES];
   logic [SEQ_W-1:0]   track_seq_ff    [TRACK_ENTRIES];
   logic [FILL_W-1:0]  track_fill_ff;
   logic [31:0]        cat_errors_ff   [NUM_CATS];

   logic               is_short;
   logic               trailer;
   logic [SEQ_W-1:0]   seq;
   logic [15:0]        overhead;
   logic [15:0]        payload;
   logic               aux_hit, iq_hit, any_pan, any_wf, pan_hit, wf_hit;
   logic               is_pan, is_wf;
   logic [CHAN_W-1:0]  aux_ch, iq_ch;
   logic [KIND_W-1:0]  kd;
   logic               sid_hit;
   category_type       cat;
   action_type         action;
   logic [CHAN_W-1:0]  chan;
   logic [1:0]         rate;
   logic               rate_ok;
   logic [TRACK_ENTRIES-1:0] hit_vec;
   logic [TRACK_W-1:0] match_idx;
   logic [SEQ_W-1:0]   match_seq;
   logic               found;
   logic               table_full;
   logic [TRACK_W-1:0] free_idx;
   logic               tracked;
   logic               seq_err;
   logic               stats_full;
   logic [2:0]         ci;
   logic [31:0]        cerr_new;

   // Packet geometry
   always_comb begin
      is_short = pkt_in.bytes < 16'(HEADER_BYTES);
      trailer  = pkt_in.word0[TRAILER_BIT];
      seq      = pkt_in.word0[SEQ_LSB +: SEQ_W];
      overhead = trailer ? 16'(HEADER_BYTES + TRAILER_BYTES) : 16'(HEADER_BYTES);
      payload  = (pkt_in.bytes > overhead) ? (pkt_in.bytes - overhead) : 16'd0;
   end

   // Slot match: lowest slot of a kind wins
   always_comb begin
      aux_hit = 1'b0;
      iq_hit  = 1'b0;
      any_pan = 1'b0;
      any_wf  = 1'b0;
      pan_hit = 1'b0;
      wf_hit  = 1'b0;
      aux_ch  = '0;
      iq_ch   = '0;
      kd      = '0;
      sid_hit = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         kd      = slot_kinds[KIND_W*s +: KIND_W];
         sid_hit = slot_id[s] == pkt_in.stream_id;
         if (kd == KIND_AUX && sid_hit && !aux_hit) begin
            aux_hit = 1'b1;
            aux_ch  = slot_channels[CHAN_W*s +: CHAN_W];
         end
         if (kd == KIND_IQ && sid_hit && !iq_hit) begin
            iq_hit = 1'b1;
            iq_ch  = slot_channels[CHAN_W*s +: CHAN_W];
         end
         if (kd == KIND_PAN) begin
            any_pan = 1'b1;
            pan_hit = pan_hit | sid_hit;
         end
         if (kd == KIND_WF) begin
            any_wf = 1'b1;
            wf_hit = wf_hit | sid_hit;
         end
      end
      is_pan = !any_pan || pan_hit;
      is_wf  = !any_wf || wf_hit;
   end

   // Category
   always_comb begin
      priority if (aux_hit || iq_hit) begin
         cat = CAT_AUX;
      end else if (pkt_in.class_code == CC_NARROW || pkt_in.class_code == CC_REDUCED ||
                   pkt_in.class_code == CC_OPUS) begin
         cat = CAT_AUDIO;
      end else if (pkt_in.class_code == CC_FFT && is_pan) begin
         cat = CAT_FFT;
      end else if (pkt_in.class_code == CC_WATERFALL && is_wf) begin
         cat = CAT_WATERFALL;
      end else if (pkt_in.class_code == CC_METER) begin
         cat = CAT_METER;
      end else begin
         cat = CAT_NONE;
      end
   end

   // Stream table lookup; a stream appears at most once
   always_comb begin
      hit_vec   = '0;
      match_idx = '0;
      match_seq = '0;
      for (int i = 0; i < TRACK_ENTRIES; i++) begin
         hit_vec[i] = (FILL_W'(i) < track_fill_ff) &&
                      (track_stream_ff[i] == pkt_in.stream_id);
         if (hit_vec[i]) begin
            match_idx = match_idx | TRACK_W'(i);
            match_seq = match_seq | track_seq_ff[i];
         end
      end
      found      = |hit_vec;
      table_full = track_fill_ff == FILL_W'(TRACK_ENTRIES);
      free_idx   = track_fill_ff[TRACK_W-1:0];
      tracked    = (cat != CAT_NONE) && !is_short;
      seq_err    = tracked && found && (seq != (match_seq + SEQ_W'(1)));
      stats_full = tracked && !found && table_full;
      ci         = 3'(cat) - 3'd1;
      cerr_new   = cat_errors_ff[ci] + 32'(seq_err);
   end

   // Action, channel, rate
   always_comb begin
      action  = ACT_DROP;
      chan    = '0;
      rate    = RATE_24K;
      rate_ok = 1'b1;
      if (aux_hit) begin
         chan = aux_ch;
         if (pkt_in.class_code == CC_NARROW) begin
            action = (payload < 16'd4) ? ACT_DROP : ACT_AUX_NARROW;
         end else if (pkt_in.class_code == CC_REDUCED) begin
            action = (payload < 16'd2) ? ACT_DROP : ACT_AUX_REDUCED;
         end
      end else if (iq_hit) begin
         chan = iq_ch;
         unique case (pkt_in.class_code)
            CC_IQ24:  rate = RATE_24K;
            CC_IQ48:  rate = RATE_48K;
            CC_IQ96:  rate = RATE_96K;
            CC_IQ192: rate = RATE_192K;
            default:  rate_ok = 1'b0;
         endcase
         if (rate_ok && payload >= 16'd8) begin
            action = ACT_IQ;
         end
      end else begin
         unique case (pkt_in.class_code)
            CC_NARROW:    action = ACT_NARROW;
            CC_REDUCED:   action = ACT_REDUCED;
            CC_OPUS:      action = ACT_OPUS;
            CC_FFT:       action = is_pan ? ACT_FFT : ACT_DROP;
            CC_WATERFALL: action = is_wf ? ACT_WATERFALL : ACT_DROP;
            CC_METER:     action = ACT_METER;
            default:      action = ACT_DROP;
         endcase
      end
   end

   // Result word; a short packet reports only its length
   always_comb begin
      rsp_out              = '0;
      rsp_out.packet_bytes = pkt_in.bytes;
      if (!is_short) begin
         rsp_out.action          = action;
         rsp_out.category        = cat;
         rsp_out.stream_id       = pkt_in.stream_id;
         rsp_out.channel         = chan;
         rsp_out.iq_rate_code    = rate;
         rsp_out.seq_error       = seq_err;
         rsp_out.payload_bytes   = payload;
         rsp_out.has_trailer     = trailer;
         rsp_out.class_code      = pkt_in.class_code;
         rsp_out.stats_full      = stats_full;
         rsp_out.category_errors = tracked ? cerr_new : 32'd0;
      end
   end

   // Table fill and error counters
   always_ff @(posedge clock) begin
      if (reset) begin
         track_fill_ff <= '0;
         for (int c = 0; c < NUM_CATS; c++) begin
            cat_errors_ff[c] <= '0;
         end
      end else if (commit && tracked) begin
         if (seq_err) begin
            cat_errors_ff[ci] <= cerr_new;
         end
         if (!found && !table_full) begin
            track_fill_ff <= track_fill_ff + FILL_W'(1);
         end
      end
   end

   // Table contents
   always_ff @(posedge clock) begin
      if (commit && tracked) begin
         if (found) begin
            track_seq_ff[match_idx] <= seq;
         end else if (!table_full) begin
            track_stream_ff[free_idx] <= pkt_in.stream_id;
            track_seq_ff[free_idx]    <= seq;
         end
      end
   end

endmodule

// ===== rtl/vpc_checker.sv =====
// ----------------------------------------------------------------------------
// vpc_checker: port-level checks for the packet classifier
// Watches the result channel and checks consistency of reported fields.
// ----------------------------------------------------------------------------
module vpc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_action,
   input  logic [2:0]  rsp_category,
   input  logic [1:0]  rsp_iq_rate_code,
   input  logic        rsp_seq_error,
   input  logic [15:0] rsp_packet_bytes,
   input  logic [15:0] rsp_payload_bytes,
   input  logic        rsp_stats_full,
   input  logic [31:0] rsp_category_errors
);
   import vpc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) &&
      $stable(rsp_category_errors))
      else $error("result changed while stalled");

   // Short datagrams report nothing but their length
   a_short_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_bytes < 16'(HEADER_BYTES) |->
      rsp_action == ACT_DROP && rsp_category == CAT_NONE && rsp_payload_bytes == 16'd0)
      else $error("short datagram not dropped");

   // Any forwarding action implies a category
   a_action_cat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_DROP |-> rsp_category != CAT_NONE)
      else $error("action without category");

   // A sequence error needs a tracked stream
   a_seq_tracked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seq_error |->
      !rsp_stats_full && rsp_category != CAT_NONE && rsp_category_errors != 32'd0)
      else $error("sequence error on untracked stream");

   // A rate code comes only from an IQ slot match
   a_rate_iq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_iq_rate_code != RATE_24K |-> rsp_category == CAT_AUX)
      else $error("rate code outside slot-matched stream");

endmodule

bind vita49_packet_classifier vpc_checker u_vpc_checker (.*);
